// File: src/cpbb_pkg.sv
`timescale 1ns / 1ps

package cpbb_pkg;

   // frame geometry, logical orientation
   localparam int LOGICAL_WIDTH  = 600;
   localparam int LOGICAL_HEIGHT = 400;
   localparam int PAD_PIXELS     = 8;

   // panel is the logical frame turned by a quarter
   localparam int PANEL_W = LOGICAL_HEIGHT;
   localparam int PANEL_H = LOGICAL_WIDTH;

   localparam int ROW_BYTES      = (LOGICAL_WIDTH + 7) / 8;
   localparam int LAST_BYTE_BITS = LOGICAL_WIDTH - 8 * (ROW_BYTES - 1);

   // leftmost pixels of the last byte of a row that lie inside the row
   localparam logic [7:0] LAST_BYTE_MASK = 8'(16'hFF00 >> LAST_BYTE_BITS);
   localparam logic [7:0] LEFT_PIXEL_MASK = 8'h80;

   localparam int CB_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int ROW_W = $clog2(LOGICAL_HEIGHT + 1);
   localparam int X_W   = $clog2(PANEL_W + 1);
   localparam int Y_W   = $clog2(PANEL_H + 1);

   // widths wide enough to hold a bound plus padding
   localparam int XP_W = $clog2(PANEL_W + PAD_PIXELS + 2);
   localparam int YP_W = $clog2(PANEL_H + PAD_PIXELS + 2);

   // result field widths
   localparam int WIN_X_W = 9;
   localparam int WIN_Y_W = 10;
   localparam int WIN_W_W = 9;
   localparam int WIN_H_W = 10;

   // configuration space
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_PREVIOUS_VALID = 1'b0;

   typedef struct packed {
      logic [7:0] new_byte;
      logic [7:0] old_byte;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      logic               changed;
      logic [WIN_X_W-1:0] win_x;
      logic [WIN_Y_W-1:0] win_y;
      logic [WIN_W_W-1:0] win_w;
      logic [WIN_H_W-1:0] win_h;
   } rsp_word_type;

   // frame summary passed from the tracker to the window stage
   typedef struct packed {
      logic           prev_valid;
      logic           seen;
      logic [X_W-1:0] least_x;
      logic [X_W-1:0] most_x;
      logic [Y_W-1:0] least_y;
      logic [Y_W-1:0] most_y;
   } frame_sum_type;

endpackage

// File: src/cpbb_tracker.sv
`timescale 1ns / 1ps

module cpbb_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cpbb_pkg::req_word_type req_word,
   input  logic                   prev_valid,
   output logic                   sum_valid,
   input  logic                   sum_take,
   output cpbb_pkg::frame_sum_type sum_word
);

   // input register
   logic                   in_valid_ff, in_valid_in;
   cpbb_pkg::req_word_type in_ff;

   // position counters and running bounds
   logic [cpbb_pkg::ROW_W-1:0] row_ff, row_in;
   logic [cpbb_pkg::CB_W-1:0]  colbyte_ff, colbyte_in;
   logic [cpbb_pkg::X_W-1:0]   least_x_ff, least_x_in, most_x_ff, most_x_in;
   logic [cpbb_pkg::Y_W-1:0]   least_y_ff, least_y_in, most_y_ff, most_y_in;
   logic                       seen_ff, seen_in;

   // frame summary register
   logic                    sum_valid_ff, sum_valid_in;
   cpbb_pkg::frame_sum_type sum_ff, sum_in;

   logic                     in_take, in_fire, active, last_byte, any_diff;
   logic [7:0]               diff;
   logic [2:0]               first_bit, last_bit;
   logic [cpbb_pkg::X_W-1:0] px;
   logic [cpbb_pkg::Y_W-1:0] py_first, py_last;

   assign in_take   = !in_ff.frame_end || !sum_valid_ff || sum_take;
   assign in_fire   = in_valid_ff && in_take;
   assign req_stall = in_valid_ff && !in_take;

   assign active    = row_ff < cpbb_pkg::ROW_W'(cpbb_pkg::LOGICAL_HEIGHT);
   assign last_byte = colbyte_ff == cpbb_pkg::CB_W'(cpbb_pkg::ROW_BYTES - 1);

   always_comb begin
      diff = (in_ff.new_byte ^ in_ff.old_byte)
             & (last_byte ? cpbb_pkg::LAST_BYTE_MASK : 8'hFF);
      any_diff = |diff;
      // leftmost and rightmost changed pixel, bit 7 is column offset 0
      first_bit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if ((diff & (cpbb_pkg::LEFT_PIXEL_MASK >> i)) != 8'h00) begin
            first_bit = 3'(i);
         end
      end
      last_bit = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if ((diff & (cpbb_pkg::LEFT_PIXEL_MASK >> i)) != 8'h00) begin
            last_bit = 3'(i);
         end
      end
   end

   assign px       = cpbb_pkg::X_W'(cpbb_pkg::LOGICAL_HEIGHT - 1) - cpbb_pkg::X_W'(row_ff);
   assign py_first = cpbb_pkg::Y_W'({colbyte_ff, first_bit});
   assign py_last  = cpbb_pkg::Y_W'({colbyte_ff, last_bit});

   always_comb begin
      row_in     = row_ff;
      colbyte_in = colbyte_ff;
      least_x_in = least_x_ff;
      most_x_in  = most_x_ff;
      least_y_in = least_y_ff;
      most_y_in  = most_y_ff;
      seen_in    = seen_ff;
      if (in_fire && active) begin
         if (any_diff) begin
            if (px < least_x_ff) begin
               least_x_in = px;
            end
            if (px > most_x_ff) begin
               most_x_in = px;
            end
            if (py_first < least_y_ff) begin
               least_y_in = py_first;
            end
            if (py_last > most_y_ff) begin
               most_y_in = py_last;
            end
            seen_in = 1'b1;
         end
         if (last_byte) begin
            colbyte_in = '0;
            row_in     = row_ff + 1'b1;
         end else begin
            colbyte_in = colbyte_ff + 1'b1;
         end
      end

      // summary takes the bounds including the final word
      sum_in.prev_valid = prev_valid;
      sum_in.seen       = seen_in;
      sum_in.least_x    = least_x_in;
      sum_in.most_x     = most_x_in;
      sum_in.least_y    = least_y_in;
      sum_in.most_y     = most_y_in;

      if (in_fire && in_ff.frame_end) begin
         row_in     = '0;
         colbyte_in = '0;
         least_x_in = cpbb_pkg::X_W'(cpbb_pkg::PANEL_W);
         most_x_in  = '0;
         least_y_in = cpbb_pkg::Y_W'(cpbb_pkg::PANEL_H);
         most_y_in  = '0;
         seen_in    = 1'b0;
      end
   end

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      priority if (in_fire && in_ff.frame_end) begin
         sum_valid_in = 1'b1;
      end else if (sum_take) begin
         sum_valid_in = 1'b0;
      end else begin
         sum_valid_in = sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
         row_ff       <= '0;
         colbyte_ff   <= '0;
         least_x_ff   <= cpbb_pkg::X_W'(cpbb_pkg::PANEL_W);
         most_x_ff    <= '0;
         least_y_ff   <= cpbb_pkg::Y_W'(cpbb_pkg::PANEL_H);
         most_y_ff    <= '0;
         seen_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         sum_valid_ff <= sum_valid_in;
         row_ff       <= row_in;
         colbyte_ff   <= colbyte_in;
         least_x_ff   <= least_x_in;
         most_x_ff    <= most_x_in;
         least_y_ff   <= least_y_in;
         most_y_ff    <= most_y_in;
         seen_ff      <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_word;
      end
      if (in_fire && in_ff.frame_end) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum_word  = sum_ff;

`ifndef SYNTH
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= cpbb_pkg::ROW_W'(cpbb_pkg::LOGICAL_HEIGHT))
      else $error("row counter ran past the frame height");

   a_colbyte_in_range: assert property (@(posedge clock) disable iff (reset)
      colbyte_ff < cpbb_pkg::CB_W'(cpbb_pkg::ROW_BYTES))
      else $error("byte counter ran past the row");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (least_x_ff <= most_x_ff) && (least_y_ff <= most_y_ff))
      else $error("bounds crossed after a change was seen");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      in_fire && in_ff.frame_end |=> !seen_ff && row_ff == '0 && colbyte_ff == '0)
      else $error("tracker not cleared after frame end");
`endif

endmodule

// File: src/cpbb_window.sv
`timescale 1ns / 1ps

module cpbb_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sum_valid,
   output logic                    sum_take,
   input  cpbb_pkg::frame_sum_type sum_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cpbb_pkg::rsp_word_type  rsp_word
);

   logic                   rsp_valid_ff, rsp_valid_in;
   cpbb_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [cpbb_pkg::XP_W-1:0] lx, mx, x0, x1, wx;
   logic [cpbb_pkg::YP_W-1:0] ly, my, y0, y1, hy;

   assign sum_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lx = cpbb_pkg::XP_W'(sum_word.least_x);
      mx = cpbb_pkg::XP_W'(sum_word.most_x) + cpbb_pkg::XP_W'(cpbb_pkg::PAD_PIXELS);
      ly = cpbb_pkg::YP_W'(sum_word.least_y);
      my = cpbb_pkg::YP_W'(sum_word.most_y) + cpbb_pkg::YP_W'(cpbb_pkg::PAD_PIXELS);

      // pad outward, clamped to the panel edges
      x0 = (lx > cpbb_pkg::XP_W'(cpbb_pkg::PAD_PIXELS))
           ? lx - cpbb_pkg::XP_W'(cpbb_pkg::PAD_PIXELS) : '0;
      y0 = (ly > cpbb_pkg::YP_W'(cpbb_pkg::PAD_PIXELS))
           ? ly - cpbb_pkg::YP_W'(cpbb_pkg::PAD_PIXELS) : '0;
      x1 = (mx > cpbb_pkg::XP_W'(cpbb_pkg::PANEL_W - 1))
           ? cpbb_pkg::XP_W'(cpbb_pkg::PANEL_W - 1) : mx;
      y1 = (my > cpbb_pkg::YP_W'(cpbb_pkg::PANEL_H - 1))
           ? cpbb_pkg::YP_W'(cpbb_pkg::PANEL_H - 1) : my;
      wx = x1 - x0 + 1'b1;
      hy = y1 - y0 + 1'b1;

      priority if (!sum_word.prev_valid) begin
         rsp_in.changed = 1'b1;
         rsp_in.win_x   = '0;
         rsp_in.win_y   = '0;
         rsp_in.win_w   = cpbb_pkg::WIN_W_W'(cpbb_pkg::PANEL_W);
         rsp_in.win_h   = cpbb_pkg::WIN_H_W'(cpbb_pkg::PANEL_H);
      end else if (sum_word.seen) begin
         rsp_in.changed = 1'b1;
         rsp_in.win_x   = cpbb_pkg::WIN_X_W'(x0);
         rsp_in.win_y   = cpbb_pkg::WIN_Y_W'(y0);
         rsp_in.win_w   = cpbb_pkg::WIN_W_W'(wx);
         rsp_in.win_h   = cpbb_pkg::WIN_H_W'(hy);
      end else begin
         rsp_in.changed = 1'b0;
         rsp_in.win_x   = '0;
         rsp_in.win_y   = '0;
         rsp_in.win_w   = '0;
         rsp_in.win_h   = '0;
      end

      priority if (sum_valid && sum_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_valid && sum_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTH
   a_unchanged_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.changed |-> rsp_ff.win_w == '0 && rsp_ff.win_h == '0)
      else $error("empty window reported with nonzero size");
`endif

endmodule

// File: src/changed_pixel_bounding_box.sv
`timescale 1ns / 1ps

// changed pixel bounding box
// req channel: one word per byte pair of a 1-bit frame in raster order, new byte,
// the previously shown byte and a frame_end flag on the last byte of the frame.
// rsp channel: one word per frame, sent for the frame_end word: changed flag and
// the padded window in panel coordinates (the frame turned a quarter turn).
// csr port: register 0 (byte address 0) holds previous_valid; when it is 0 the
// window is always the full panel. it is sampled when the frame_end word is taken.
// throughput: one req word per cycle while req_stall is low; the tracker folds every
// word inside the frame into its bounds. a frame_end word goes from the input register
// to the summary register, then through the window math into the output register.
// the output register decouples the sides: while a result waits under rsp_stall,
// ordinary req words keep flowing and the next frame_end word parks in the summary
// register; req_stall rises once a further frame_end word reaches the input register.
// reset (synchronous, active high) clears the counters, the bounds, previous_valid
// and every valid flag; no clearing pass is needed.

module changed_pixel_bounding_box (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cpbb_pkg::req_word_type             req_word,
   // result words
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cpbb_pkg::rsp_word_type             rsp_word,
   // configuration
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cpbb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [cpbb_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [cpbb_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   logic                                 prev_valid_ff, prev_valid_in;
   logic [cpbb_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic                                 sum_valid, sum_take;
   cpbb_pkg::frame_sum_type              sum_word;

   // registers sit on 32-bit boundaries, low address bits select nothing
   assign csr_index = paddr[cpbb_pkg::CSR_ADDR_W-1:2];
   assign pready    = 1'b1;

   always_comb begin
      prev_valid_in = prev_valid_ff;
      if (psel && penable && pwrite && pready
          && csr_index == cpbb_pkg::REG_PREVIOUS_VALID) begin
         prev_valid_in = pwdata[0];
      end
   end

   assign prdata = (csr_index == cpbb_pkg::REG_PREVIOUS_VALID)
                   ? cpbb_pkg::CSR_DATA_W'(prev_valid_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
      end
   end

   // byte counters and running min/max, frame summary at frame end
   cpbb_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .prev_valid (prev_valid_ff),
      .sum_valid  (sum_valid),
      .sum_take   (sum_take),
      .sum_word   (sum_word)
   );

   // padding, clamping and size, into the output register
   cpbb_window u_window (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum_take  (sum_take),
      .sum_word  (sum_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// File: bench/tb_changed_pixel_bounding_box.sv
`timescale 1ns / 1ps

module tb_changed_pixel_bounding_box;

   // cycles with no handshake of any kind before the run is declared hung;
   // the longest legal quiet stretch is the output hold-off plus a long gap
   localparam int IDLE_LIMIT     = 5000;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int RANDOM_WORDS   = 880;
   // a frame_end word passes the summary and output registers first, keep a margin
   localparam int DRAIN_CYCLES   = 10;
   localparam logic [cpbb_pkg::CSR_ADDR_W-1:0] PREV_VALID_ADDR =
      {cpbb_pkg::REG_PREVIOUS_VALID, 2'b00};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   cpbb_pkg::req_word_type          req_word = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   cpbb_pkg::rsp_word_type          rsp_word;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [cpbb_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [cpbb_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [cpbb_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   changed_pixel_bounding_box i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // bounding box tracker: our own copy of the frame state
   // ---------------------------------------------------------------------------
   int           row_cnt;
   int           byte_cnt;
   int           least_x, most_x, least_y, most_y;
   bit           any_change;
   bit           prev_frame_ok;

   cpbb_pkg::rsp_word_type window_queue[$];   // windows still owed by the block

   int errors          = 0;
   int words_sent      = 0;
   int windows_checked = 0;
   int changed_windows = 0;
   int csr_writes      = 0;
   int hold_off_left   = 0;         // set by a test, counted down by the stall driver

   function automatic void clear_bounds();
      row_cnt    = 0;
      byte_cnt   = 0;
      least_x    = cpbb_pkg::PANEL_W;
      most_x     = 0;
      least_y    = cpbb_pkg::PANEL_H;
      most_y     = 0;
      any_change = 1'b0;
   endfunction

   // fold one byte pair into the bounds; returns 1 with the window on frame_end
   function automatic bit fold_byte_pair(input cpbb_pkg::req_word_type w,
                                         output cpbb_pkg::rsp_word_type win);
      logic [7:0] diff;
      int         col, px, x0, y0, x1, y1;
      diff = w.new_byte ^ w.old_byte;
      win  = '0;
      // once every row has been seen, stray bytes are dropped until frame_end
      if (row_cnt < cpbb_pkg::LOGICAL_HEIGHT) begin
         for (int b = 0; b < 8; b++) begin
            col = byte_cnt * 8 + b;
            // pixels past the logical width in the last byte of a row don't count
            if (col < cpbb_pkg::LOGICAL_WIDTH
                && (diff & (cpbb_pkg::LEFT_PIXEL_MASK >> b)) != 0) begin
               // quarter turn: logical row counts down the panel x axis
               px = cpbb_pkg::LOGICAL_HEIGHT - 1 - row_cnt;
               if (px < least_x) least_x = px;
               if (px > most_x) most_x = px;
               if (col < least_y) least_y = col;
               if (col > most_y) most_y = col;
               any_change = 1'b1;
            end
         end
         byte_cnt++;
         if (byte_cnt >= cpbb_pkg::ROW_BYTES) begin
            byte_cnt = 0;
            row_cnt++;
         end
      end
      if (!w.frame_end) return 1'b0;

      if (!prev_frame_ok) begin
         // nothing to compare against: repaint the whole panel
         win.changed = 1'b1;
         win.win_w   = cpbb_pkg::WIN_W_W'(cpbb_pkg::PANEL_W);
         win.win_h   = cpbb_pkg::WIN_H_W'(cpbb_pkg::PANEL_H);
      end else if (any_change) begin
         // pad each side, clamped to the panel edges
         x0 = (least_x > cpbb_pkg::PAD_PIXELS) ? least_x - cpbb_pkg::PAD_PIXELS : 0;
         y0 = (least_y > cpbb_pkg::PAD_PIXELS) ? least_y - cpbb_pkg::PAD_PIXELS : 0;
         x1 = most_x + cpbb_pkg::PAD_PIXELS;
         y1 = most_y + cpbb_pkg::PAD_PIXELS;
         if (x1 > cpbb_pkg::PANEL_W - 1) x1 = cpbb_pkg::PANEL_W - 1;
         if (y1 > cpbb_pkg::PANEL_H - 1) y1 = cpbb_pkg::PANEL_H - 1;
         win.changed = 1'b1;
         win.win_x   = cpbb_pkg::WIN_X_W'(x0);
         win.win_y   = cpbb_pkg::WIN_Y_W'(y0);
         win.win_w   = cpbb_pkg::WIN_W_W'(x1 - x0 + 1);
         win.win_h   = cpbb_pkg::WIN_H_W'(y1 - y0 + 1);
      end
      // no change with a valid previous frame leaves the window all zero
      clear_bounds();
      return 1'b1;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // random pacing
   // ---------------------------------------------------------------------------

   // sender gap: mostly back to back, some short pauses, rare long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // which pixels differ in a byte: usually none, sometimes one, sometimes any
   function automatic logic [7:0] pick_diff();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 8'h00;
      if (r < 90) return cpbb_pkg::LEFT_PIXEL_MASK >> $urandom_range(0, 7);
      return 8'($urandom);
   endfunction

   // result side stall: runs of flow and runs of stall, plus the hold-off on request
   int stall_run = 0;
   always @(posedge clock) begin : drive_rsp_stall
      int r;
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(0, 20);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(10, 40);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result checker: every accepted word against the oldest owed window
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_windows
      cpbb_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (window_queue.size() == 0) begin
            $display("%0t ns: result word with no window owed, actual %h", $time, rsp_word);
            errors++;
         end else begin
            want = window_queue.pop_front();
            check_field("changed", want.changed, rsp_word.changed);
            check_field("win_x",   want.win_x,   rsp_word.win_x);
            check_field("win_y",   want.win_y,   rsp_word.win_y);
            check_field("win_w",   want.win_w,   rsp_word.win_w);
            check_field("win_h",   want.win_h,   rsp_word.win_h);
            windows_checked++;
            if (want.changed) changed_windows++;
         end
      end
   end

   // watchdog: any handshake on any port counts as progress
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ---------------------------------------------------------------------------
   // shared tasks, all entered right after a rising edge
   // ---------------------------------------------------------------------------

   // offer one word, hold it until taken, then optionally go quiet for a gap
   task automatic send_word(input cpbb_pkg::req_word_type w, input int gap);
      cpbb_pkg::rsp_word_type win;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (fold_byte_pair(w, win)) window_queue.push_back(win);
      if (gap > 0) begin
         // junk on the bus while valid is low
         req_valid <= 1'b0;
         req_word  <= cpbb_pkg::req_word_type'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, let every owed window come out, then let the pipe settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (window_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit is_write,
                             input logic [cpbb_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [cpbb_pkg::CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= PREV_VALID_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // write previous_valid only with the block idle, then read it back
   task automatic set_previous_valid(input bit v);
      logic [cpbb_pkg::CSR_DATA_W-1:0] got;
      wait_for_idle();
      // upper bits carry junk, only bit 0 is the register
      csr_access(1'b1, (cpbb_pkg::CSR_DATA_W'($urandom) & ~cpbb_pkg::CSR_DATA_W'(1))
                       | cpbb_pkg::CSR_DATA_W'(v), got);
      prev_frame_ok = v;
      csr_writes++;
      csr_access(1'b0, '0, got);
      check_field("previous_valid readback", v, got[0]);
   endtask

   task automatic send_random_frame(input int len);
      cpbb_pkg::req_word_type w;
      for (int i = 0; i < len; i++) begin
         w.new_byte  = 8'($urandom);
         w.old_byte  = w.new_byte ^ pick_diff();
         w.frame_end = (i == len - 1);
         send_word(w, pick_gap());
      end
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // register comes out of reset at 0 and takes both values
   task automatic test_register_access();
      logic [cpbb_pkg::CSR_DATA_W-1:0] got;
      csr_access(1'b0, '0, got);
      check_field("previous_valid after reset", 0, got[0]);
      set_previous_valid(1'b1);
      set_previous_valid(1'b0);
   endtask

   // no previous frame: full panel no matter what the pixels say
   task automatic test_no_previous_frame();
      set_previous_valid(1'b0);
      send_word('{new_byte: 8'h00, old_byte: 8'h00, frame_end: 1'b1}, pick_gap());
      send_word('{new_byte: 8'hFF, old_byte: 8'h00, frame_end: 1'b0}, pick_gap());
      send_word('{new_byte: 8'h00, old_byte: 8'h00, frame_end: 1'b1}, pick_gap());
   endtask

   // short frames that hit the field extremes, no change, both edge pixels
   // and the clamps at panel x max and panel y zero
   task automatic test_short_frames();
      set_previous_valid(1'b1);
      send_word('{new_byte: 8'h00, old_byte: 8'h00, frame_end: 1'b1}, pick_gap());
      send_word('{new_byte: 8'hFF, old_byte: 8'hFF, frame_end: 1'b1}, pick_gap());
      send_word('{new_byte: 8'hFF, old_byte: 8'h00, frame_end: 1'b1}, pick_gap());
      send_word('{new_byte: 8'h00, old_byte: 8'hFF, frame_end: 1'b1}, pick_gap());
      send_word('{new_byte: 8'h80, old_byte: 8'h00, frame_end: 1'b1}, pick_gap());
      send_word('{new_byte: 8'h00, old_byte: 8'h01, frame_end: 1'b1}, pick_gap());
      // early frame_end after a few bytes, change only in the middle byte
      send_word('{new_byte: 8'h12, old_byte: 8'h12, frame_end: 1'b0}, pick_gap());
      send_word('{new_byte: 8'h5A, old_byte: 8'h5B, frame_end: 1'b0}, pick_gap());
      send_word('{new_byte: 8'hC3, old_byte: 8'hC3, frame_end: 1'b1}, pick_gap());
   endtask

   // a few whole rows and a bit: byte counter wraps into the next row, the last
   // column of a row (panel y clamp at the far edge) and the first column
   task automatic test_row_wrap();
      cpbb_pkg::req_word_type w;
      int                     total, idx_right, idx_mid, idx_left;
      set_previous_valid(1'b1);
      total     = 3 * cpbb_pkg::ROW_BYTES + 2;
      idx_right = cpbb_pkg::ROW_BYTES - 1;
      idx_mid   = cpbb_pkg::ROW_BYTES + 40;
      idx_left  = 2 * cpbb_pkg::ROW_BYTES;
      for (int i = 0; i < total; i++) begin
         w.new_byte = 8'($urandom);
         w.old_byte = w.new_byte;
         if (i == idx_right) w.old_byte = w.new_byte ^ 8'h01;
         if (i == idx_mid)   w.old_byte = w.new_byte ^ 8'h10;
         if (i == idx_left)  w.old_byte = w.new_byte ^ 8'h80;
         w.frame_end = (i == total - 1);
         send_word(w, (pick_gap() > 3) ? 1 : 0);
      end
   endtask

   // random frames of mixed length, register rewritten now and then between frames
   task automatic test_random_frames();
      int start, r, len;
      start = words_sent;
      set_previous_valid(1'b1);
      while (words_sent - start < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 70)      len = $urandom_range(1, 30);
         else if (r < 90) len = $urandom_range(31, 160);
         else             len = $urandom_range(161, 450);
         send_random_frame(len);
         if ($urandom_range(0, 7) == 0)
            set_previous_valid($urandom_range(0, 99) < 85);
      end
   endtask

   // result side held off for a long stretch while tiny frames keep coming,
   // so the output register fills and the input side has to stall
   task automatic test_output_hold_off();
      set_previous_valid(1'b1);
      hold_off_left = HOLD_OFF_LEN;
      for (int f = 0; f < 40; f++) begin
         for (int i = 0; i < 3; i++)
            send_word('{new_byte: 8'($urandom), old_byte: 8'($urandom),
                        frame_end: (i == 2)}, 0);
      end
      wait_for_idle();
   endtask

   initial begin
      prev_frame_ok = 1'b0;
      clear_bounds();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_no_previous_frame();
      test_short_frames();
      test_row_wrap();
      test_random_frames();
      test_output_hold_off();

      // drain and give a stray extra word time to show up
      wait_for_idle();

      $display("sent %0d words, checked %0d windows (%0d with a change)",
               words_sent, windows_checked, changed_windows);
      $display("%0d register writes, one multi-row frame, one output hold-off",
               csr_writes);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
src/cpbb_pkg.sv
src/cpbb_tracker.sv
src/cpbb_window.sv
src/changed_pixel_bounding_box.sv
bench/tb_changed_pixel_bounding_box.sv
